/* hdl/msps_pkg.sv */
// shared types, action codes, coil sequence tables and reset values
// for the stepper phase sequencer; no dependencies
`default_nettype none

package msps_pkg;

  // default build values
  localparam int unsigned NUM_MOTORS_DEF = 4;
  localparam int unsigned SEQ_LEN_DEF    = 4;

  // field widths
  localparam int unsigned ACT_W    = 4;
  localparam int unsigned MOTOR_W  = 2;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned COIL_W   = 4;
  localparam int unsigned CHOP_W   = 7;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_TICK     = 4'd0,
    ACT_STEP_UP  = 4'd1,
    ACT_STEP_DN  = 4'd2,
    ACT_FREE_UP  = 4'd3,
    ACT_FREE_DN  = 4'd4,
    ACT_STOP_ONE = 4'd5,
    ACT_STOP_ALL = 4'd6,
    ACT_SET_POS  = 4'd7,
    ACT_READ     = 4'd8
  } action_e;

  // one-phase-on and half-step coil tables
  localparam logic [COIL_W-1:0] FULL_SEQ [4] = '{4'h1, 4'h4, 4'h2, 4'h8};
  localparam logic [COIL_W-1:0] HALF_SEQ [8] =
    '{4'h1, 4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9};

  // chop reload values after reset, one per motor
  localparam logic [CHOP_W-1:0] RELOAD_RST [4] = '{7'd4, 7'd4, 7'd3, 7'd0};

  // command from the top level to one motor
  typedef struct packed {
    logic                    fire;
    action_e                 action;
    logic                    sel;
    logic [POS_W-1:0]        new_pos;
    logic [CHOP_W-1:0]       reload;
  } motor_cmd_t;

  // status from one motor: tick nibble and next position and phase
  typedef struct packed {
    logic [COIL_W-1:0]  nibble;
    logic [POS_W-1:0]   pos;
    logic [PHASE_W-1:0] phase;
  } motor_stat_t;

  // coil pattern for a phase index
  function automatic logic [COIL_W-1:0] pattern_for(logic [PHASE_W-1:0] idx,
                                                    int unsigned seq_len);
    logic [COIL_W-1:0] pat;
    if (seq_len == 8) begin
      pat = HALF_SEQ[idx];
    end else begin
      pat = FULL_SEQ[idx[1:0]];
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

/* hdl/msps_motor.sv */
// state of one stepper motor: phase index, held pattern, position, chop count
// depends on msps_pkg
`default_nettype none

module msps_motor #(
  parameter int unsigned SEQ_LEN = msps_pkg::SEQ_LEN_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  msps_pkg::motor_cmd_t   cmd_i,
  output msps_pkg::motor_stat_t  stat_o
);

  localparam logic [msps_pkg::PHASE_W:0] SeqLenW = (msps_pkg::PHASE_W+1)'(SEQ_LEN);
  localparam logic [msps_pkg::PHASE_W-1:0] LastPh = msps_pkg::PHASE_W'(SEQ_LEN - 1);

  logic [msps_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [msps_pkg::COIL_W-1:0]  held_q, held_d;
  logic [msps_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [msps_pkg::CHOP_W-1:0]  count_q, count_d;
  logic [msps_pkg::PHASE_W:0]   phase_inc;
  logic                         up;

  assign phase_inc = {1'b0, phase_q} + 1'b1;

  // next state for one command
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    pos_d   = pos_q;
    count_d = count_q;
    up      = (cmd_i.action == msps_pkg::ACT_STEP_UP) ||
              (cmd_i.action == msps_pkg::ACT_FREE_UP);
    case (cmd_i.action) inside
      msps_pkg::ACT_TICK: begin
        if (count_q == '0) begin
          count_d = cmd_i.reload;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      msps_pkg::ACT_STEP_UP, msps_pkg::ACT_STEP_DN,
      msps_pkg::ACT_FREE_UP, msps_pkg::ACT_FREE_DN: begin
        if (cmd_i.sel) begin
          if (up) begin
            phase_d = (phase_inc >= SeqLenW) ? '0 : phase_inc[msps_pkg::PHASE_W-1:0];
          end else if (phase_q == '0 || {1'b0, phase_q} >= SeqLenW) begin
            phase_d = LastPh;
          end else begin
            phase_d = phase_q - 1'b1;
          end
          held_d = msps_pkg::pattern_for(phase_d, SEQ_LEN);
          if (cmd_i.action == msps_pkg::ACT_STEP_UP) begin
            pos_d = pos_q + 1'b1;
          end else if (cmd_i.action == msps_pkg::ACT_STEP_DN) begin
            pos_d = pos_q - 1'b1;
          end
        end
      end
      msps_pkg::ACT_STOP_ONE: begin
        if (cmd_i.sel) begin
          held_d = '0;
        end
      end
      msps_pkg::ACT_STOP_ALL: begin
        held_d = '0;
      end
      msps_pkg::ACT_SET_POS: begin
        if (cmd_i.sel) begin
          pos_d = cmd_i.new_pos;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
      pos_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.fire) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      pos_q   <= pos_d;
      count_q <= count_d;
    end
  end

  // coils driven on a tick only when the countdown is at zero
  assign stat_o.nibble = (count_q == '0) ? held_q : '0;
  assign stat_o.pos    = pos_d;
  assign stat_o.phase  = phase_d;

endmodule

`default_nettype wire

/* hdl/multi_stepper_phase_sequencer.sv */
// Stepper phase sequencer for up to four motors, coil word in nibbles.
// Input register, then result register; one item per cycle while the output
// accepts, set by the single read-modify-write of the motor state between
// the two registers; a stalled output holds both registers.
// Reset: all motor state and the coil word clear, chop reloads go to 4,4,3,0.
// depends on msps_pkg and msps_motor
`default_nettype none

module multi_stepper_phase_sequencer #(
  parameter int unsigned NUM_MOTORS = msps_pkg::NUM_MOTORS_DEF,
  parameter int unsigned SEQ_LEN    = msps_pkg::SEQ_LEN_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [6:0]  cfg_data_i,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // new_position[15:0]
  input  wire  [5:0]  s_axis_tuser,   // action[3:0], motor[5:4]
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata    // coil_drive[15:0], position[31:16],
                                      // phase_index[34:32], zero[39:35]
);

  localparam int unsigned PW = msps_pkg::PHASE_W;

  // input register
  logic                          in_valid_q;
  msps_pkg::action_e             in_action_q;
  logic [msps_pkg::MOTOR_W-1:0]  in_motor_q;
  logic [msps_pkg::POS_W-1:0]    in_pos_q;

  // result register
  logic                          out_valid_q;
  logic [msps_pkg::WORD_W-1:0]   out_coil_q;
  logic [msps_pkg::POS_W-1:0]    out_pos_q, out_pos_d;
  logic [PW-1:0]                 out_phase_q, out_phase_d;

  logic [msps_pkg::WORD_W-1:0]   coil_latch_q, coil_latch_d;
  logic [msps_pkg::CHOP_W-1:0]   reload_q [NUM_MOTORS];

  logic                          advance, fire, present, s_take;
  msps_pkg::motor_stat_t         stat [NUM_MOTORS];

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;
  assign present       = {30'd0, in_motor_q} < NUM_MOTORS;

  // chop reload registers
  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_reload
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        reload_q[g] <= msps_pkg::RELOAD_RST[g];
      end else if (cfg_valid_i && cfg_index_i == msps_pkg::CFG_IDX_W'(g)) begin
        reload_q[g] <= cfg_data_i;
      end
    end
  end

  // per-motor state
  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_motor
    msps_pkg::motor_cmd_t cmd;
    assign cmd.fire    = fire;
    assign cmd.action  = in_action_q;
    assign cmd.sel     = (in_motor_q == msps_pkg::MOTOR_W'(g));
    assign cmd.new_pos = in_pos_q;
    assign cmd.reload  = reload_q[g];

    msps_motor #(
      .SEQ_LEN (SEQ_LEN)
    ) u_motor (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .stat_o (stat[g])
    );
  end

  // coil word and addressed motor readback
  always_comb begin
    coil_latch_d = coil_latch_q;
    out_pos_d    = '0;
    out_phase_d  = '0;
    if (in_action_q == msps_pkg::ACT_TICK) begin
      coil_latch_d = '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        coil_latch_d[4*i +: 4] = stat[i].nibble;
      end
    end
    for (int i = 0; i < NUM_MOTORS; i++) begin
      if (in_motor_q == msps_pkg::MOTOR_W'(i)) begin
        out_pos_d   = stat[i].pos;
        out_phase_d = stat[i].phase;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      coil_latch_q <= '0;
    end else begin
      if (s_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        coil_latch_q <= coil_latch_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_action_q <= msps_pkg::action_e'(s_axis_tuser[3:0]);
      in_motor_q  <= s_axis_tuser[5:4];
      in_pos_q    <= s_axis_tdata;
    end
    if (fire) begin
      out_coil_q  <= coil_latch_d;
      out_pos_q   <= out_pos_d;
      out_phase_q <= out_phase_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_phase_q, out_pos_q, out_coil_q};

  // coil word only changes on a tick
  a_coil_tick_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!fire || in_action_q != msps_pkg::ACT_TICK) |=> $stable(coil_latch_q))
    else $error("coil word changed without a tick");

  // a held item stays in the input register
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input item dropped while stalled");

  // an absent motor reads back as zero
  a_absent_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !present) |=> (out_pos_q == '0 && out_phase_q == '0))
    else $error("absent motor readback not zero");

endmodule

`default_nettype wire
